// ===== hw/rtl/form_field_extract_decode_top_macros.svh =====
// Assertion macros shared by the form decoder checker.
`ifndef FORM_FIELD_EXTRACT_DECODE_TOP_MACROS_SVH
`define FORM_FIELD_EXTRACT_DECODE_TOP_MACROS_SVH

// Same-cycle implication, checked on every clock outside reset.
`define FFD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("form decoder check failed");

// Next-cycle implication, checked on every clock outside reset.
`define FFD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("form decoder check failed");

`endif

// ===== hw/rtl/ffd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ffd_pkg;

    // Longest key the matcher compares
    localparam int unsigned MAX_KEY_BYTES = 8;

    // Configuration register indexes
    localparam logic [1:0] CFG_FIELD_KEY      = 2'd0;
    localparam logic [1:0] CFG_KEY_LENGTH     = 2'd1;
    localparam logic [1:0] CFG_VALUE_CAPACITY = 2'd2;

    // Outcome codes
    localparam logic [2:0] OC_OK         = 3'd0;
    localparam logic [2:0] OC_NOT_FOUND  = 3'd1;
    localparam logic [2:0] OC_BAD_ESCAPE = 3'd2;
    localparam logic [2:0] OC_OVERFLOW   = 3'd3;
    localparam logic [2:0] OC_ZERO       = 3'd4;

    // Characters of the form syntax
    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_AMP     = 8'h26;
    localparam logic [7:0] CH_EQUAL   = 8'h3D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_DIGIT_0 = 8'h30;
    localparam logic [7:0] CH_DIGIT_9 = 8'h39;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_F = 8'h66;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_F = 8'h46;

    // Hex digit decode result
    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_nibble;

    function automatic t_nibble hex_nibble(input logic [7:0] c);
        t_nibble res;
        logic [7:0] diff;
        res  = '0;
        diff = '0;
        case (c) inside
            [CH_DIGIT_0:CH_DIGIT_9]: begin
                diff    = c - CH_DIGIT_0;
                res.ok  = 1'b1;
                res.val = diff[3:0];
            end
            [CH_LOWER_A:CH_LOWER_F]: begin
                diff    = c - CH_LOWER_A + 8'd10;
                res.ok  = 1'b1;
                res.val = diff[3:0];
            end
            [CH_UPPER_A:CH_UPPER_F]: begin
                diff    = c - CH_UPPER_A + 8'd10;
                res.ok  = 1'b1;
                res.val = diff[3:0];
            end
            default: begin
                res = '0;
            end
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/form_field_extract_decode_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// URL-encoded form field decoder. Body bytes arrive one per transfer on the
// input channel; every accepted byte yields exactly one registered result
// transfer, carrying an optional decoded value byte and, on the byte that
// settles it, the finished flag and outcome. Unless a result is stalled, one
// byte is taken every clock: the whole per-byte step (key compare, hex merge,
// capacity compare) sits between the state registers and the output register,
// and the output register lets a new byte in while its result is being taken.
// After an outcome the rest of the body up to the byte marked last is dropped
// (each still gives an all-zero result). Configuration writes apply at once.
module form_field_extract_decode_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration write port
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [63:0] i_cfg_data,
    // input channel
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_body_byte,
    input  wire logic        i_last_byte,
    // output channel
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [7:0]       o_value_byte,
    output logic             o_byte_valid,
    output logic             o_finished,
    output logic [2:0]       o_outcome
);

    // Phase codes
    localparam logic [2:0] PH_MATCH  = 3'd0;
    localparam logic [2:0] PH_SKIP   = 3'd1;
    localparam logic [2:0] PH_VALUE  = 3'd2;
    localparam logic [2:0] PH_ESC_HI = 3'd3;
    localparam logic [2:0] PH_ESC_LO = 3'd4;
    localparam logic [2:0] PH_DONE   = 3'd5;

    localparam logic [3:0] KEY_MAX = 4'(ffd_pkg::MAX_KEY_BYTES);

    // configuration
    logic [63:0] r_field_key;
    logic [3:0]  r_key_length;
    logic [7:0]  r_value_capacity;

    // parse state
    logic [2:0]  r_phase,         n_phase;
    logic [3:0]  r_match_pos,     n_match_pos;
    logic [3:0]  r_high_nib,      n_high_nib;
    logic [7:0]  r_bytes_written, n_bytes_written;

    // output register
    logic        r_out_valid;
    logic [7:0]  r_value_byte,    n_value_byte;
    logic        r_byte_valid,    n_byte_valid;
    logic        r_finished,      n_finished;
    logic [2:0]  r_outcome,       n_outcome;

    logic            accept;
    logic [3:0]      klen;
    logic [7:0]      key_char;
    logic            cap_full;
    ffd_pkg::t_nibble nib;
    logic [7:0]      esc_byte;

    // Outcome when the text ends in a given phase
    function automatic logic [2:0] end_outcome(input logic [2:0] ph);
        logic [2:0] oc;
        oc = ffd_pkg::OC_NOT_FOUND;
        if (ph == PH_VALUE) begin
            oc = ffd_pkg::OC_OK;
        end else if (ph == PH_ESC_HI || ph == PH_ESC_LO) begin
            oc = ffd_pkg::OC_BAD_ESCAPE;
        end
        return oc;
    endfunction

    // Accept when the output slot is free or is being taken this cycle
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    // Per-byte helpers
    assign klen     = (r_key_length > KEY_MAX) ? KEY_MAX : r_key_length;
    assign key_char = r_field_key[{r_match_pos[2:0], 3'b000} +: 8];
    assign cap_full = ({1'b0, r_bytes_written} + 9'd1) >= {1'b0, r_value_capacity};
    assign nib      = ffd_pkg::hex_nibble(i_body_byte);
    assign esc_byte = {r_high_nib, nib.val};

    // One parse step
    always_comb begin
        n_phase         = r_phase;
        n_match_pos     = r_match_pos;
        n_high_nib      = r_high_nib;
        n_bytes_written = r_bytes_written;
        n_value_byte    = 8'd0;
        n_byte_valid    = 1'b0;
        n_finished      = 1'b0;
        n_outcome       = ffd_pkg::OC_OK;

        if (r_phase == PH_DONE) begin
            // dropping the rest of the body
            if (i_last_byte) begin
                n_phase         = PH_MATCH;
                n_match_pos     = 4'd0;
                n_high_nib      = 4'd0;
                n_bytes_written = 8'd0;
            end
        end else begin
            if (i_body_byte == ffd_pkg::CH_NUL) begin
                n_outcome  = end_outcome(r_phase);
                n_finished = 1'b1;
            end else begin
                case (r_phase)
                    PH_MATCH: begin
                        if (i_body_byte == ffd_pkg::CH_AMP) begin
                            n_match_pos = 4'd0;
                        end else if (r_match_pos < klen) begin
                            if (i_body_byte == key_char) begin
                                n_match_pos = r_match_pos + 4'd1;
                            end else begin
                                n_phase = PH_SKIP;
                            end
                        end else if (i_body_byte == ffd_pkg::CH_EQUAL) begin
                            n_phase         = PH_VALUE;
                            n_bytes_written = 8'd0;
                        end else begin
                            n_phase = PH_SKIP;
                        end
                    end
                    PH_SKIP: begin
                        if (i_body_byte == ffd_pkg::CH_AMP) begin
                            n_phase     = PH_MATCH;
                            n_match_pos = 4'd0;
                        end
                    end
                    PH_VALUE: begin
                        if (i_body_byte == ffd_pkg::CH_AMP) begin
                            n_outcome  = ffd_pkg::OC_OK;
                            n_finished = 1'b1;
                        end else if (cap_full) begin
                            n_outcome  = ffd_pkg::OC_OVERFLOW;
                            n_finished = 1'b1;
                        end else if (i_body_byte == ffd_pkg::CH_PERCENT) begin
                            n_phase = PH_ESC_HI;
                        end else begin
                            n_value_byte = (i_body_byte == ffd_pkg::CH_PLUS) ?
                                           ffd_pkg::CH_SPACE : i_body_byte;
                            n_byte_valid = 1'b1;
                        end
                    end
                    PH_ESC_HI: begin
                        if (!nib.ok) begin
                            n_outcome  = ffd_pkg::OC_BAD_ESCAPE;
                            n_finished = 1'b1;
                        end else begin
                            n_high_nib = nib.val;
                            n_phase    = PH_ESC_LO;
                        end
                    end
                    PH_ESC_LO: begin
                        if (!nib.ok) begin
                            n_outcome  = ffd_pkg::OC_BAD_ESCAPE;
                            n_finished = 1'b1;
                        end else if (esc_byte == 8'd0) begin
                            n_outcome  = ffd_pkg::OC_ZERO;
                            n_finished = 1'b1;
                        end else begin
                            n_value_byte = esc_byte;
                            n_byte_valid = 1'b1;
                            n_phase      = PH_VALUE;
                        end
                    end
                    default: begin
                        n_phase = PH_DONE;
                    end
                endcase
            end

            if (n_byte_valid) begin
                n_bytes_written = r_bytes_written + 8'd1;
            end

            // last byte settles the outcome from the phase it leaves behind
            if (!n_finished && i_last_byte) begin
                n_outcome  = end_outcome(n_phase);
                n_finished = 1'b1;
            end

            if (n_finished) begin
                if (i_last_byte) begin
                    n_phase         = PH_MATCH;
                    n_match_pos     = 4'd0;
                    n_high_nib      = 4'd0;
                    n_bytes_written = 8'd0;
                end else begin
                    n_phase = PH_DONE;
                end
            end
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_field_key      <= 64'd0;
            r_key_length     <= 4'd1;
            r_value_capacity <= 8'd64;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ffd_pkg::CFG_FIELD_KEY:      r_field_key      <= i_cfg_data;
                ffd_pkg::CFG_KEY_LENGTH:     r_key_length     <= i_cfg_data[3:0];
                ffd_pkg::CFG_VALUE_CAPACITY: r_value_capacity <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    // Parse state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_MATCH;
            r_match_pos     <= 4'd0;
            r_high_nib      <= 4'd0;
            r_bytes_written <= 8'd0;
            r_out_valid     <= 1'b0;
        end else begin
            if (accept) begin
                r_phase         <= n_phase;
                r_match_pos     <= n_match_pos;
                r_high_nib      <= n_high_nib;
                r_bytes_written <= n_bytes_written;
                r_out_valid     <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid     <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_value_byte <= n_value_byte;
            r_byte_valid <= n_byte_valid;
            r_finished   <= n_finished;
            r_outcome    <= n_outcome;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_value_byte = r_value_byte;
    assign o_byte_valid = r_byte_valid;
    assign o_finished   = r_finished;
    assign o_outcome    = r_outcome;

endmodule

`default_nettype wire

// ===== hw/rtl/ffd_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "form_field_extract_decode_top_macros.svh"

// Port-level checks on the form decoder
module ffd_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       o_in_ready,
    input wire logic       o_out_valid,
    input wire logic       i_out_ready,
    input wire logic [7:0] o_value_byte,
    input wire logic       o_byte_valid,
    input wire logic       o_finished,
    input wire logic [2:0] o_outcome
);

    logic [12:0] out_payload;

    assign out_payload = {o_value_byte, o_byte_valid, o_finished, o_outcome};

    // a stalled result holds
    `FFD_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(out_payload))

    // every accepted byte shows a result on the next cycle
    `FFD_ASSERT_NEXT(a_result_follows, i_in_valid && o_in_ready, o_out_valid)

    // outcome is zero unless the result settles the body
    `FFD_ASSERT_SAME(a_outcome_quiet, o_out_valid && !o_finished, o_outcome == ffd_pkg::OC_OK)

    // empty bytes are zero
    `FFD_ASSERT_SAME(a_empty_zero, o_out_valid && !o_byte_valid, o_value_byte == 8'd0)

    // no data byte rides along with a failed decode
    `FFD_ASSERT_SAME(a_byte_ok, o_out_valid && o_byte_valid && o_finished, o_outcome == ffd_pkg::OC_OK)

endmodule

bind form_field_extract_decode_top ffd_checker u_ffd_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_ready   (o_in_ready),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_value_byte (o_value_byte),
    .o_byte_valid (o_byte_valid),
    .o_finished   (o_finished),
    .o_outcome    (o_outcome)
);

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned STALL_LIMIT  = 4000;
    localparam int unsigned ITEMS_TARGET = 750;
    localparam int unsigned MAX_REPORTS  = 10;
    localparam int unsigned DRAIN_CYCLES = 4;

    // Decoder state as the predictor tracks it
    typedef enum logic [2:0] {
        ST_KEY, ST_SKIP, ST_VALUE, ST_ESC_HI, ST_ESC_LO, ST_DRAIN
    } t_dec_state;

    // One result transfer
    typedef struct packed {
        logic [7:0] value_byte;
        logic       byte_valid;
        logic       finished;
        logic [2:0] outcome;
    } t_dec_result;

    // Predicts the decoder byte by byte and checks its results in order
    class form_decode_scoreboard;
        logic [63:0] field_key;
        logic [3:0]  key_len;
        logic [7:0]  capacity;
        t_dec_state  state;
        logic [3:0]  match_pos;
        logic [3:0]  hi_nib;
        logic [7:0]  written;
        t_dec_result pending[$];
        int unsigned mismatches;
        int unsigned results_checked;
        int unsigned bytes_decoded;
        int unsigned outcome_tally[5];

        function new();
            field_key       = '0;
            key_len         = 4'd1;
            capacity        = 8'd64;
            mismatches      = 0;
            results_checked = 0;
            bytes_decoded   = 0;
            foreach (outcome_tally[i]) outcome_tally[i] = 0;
            restart();
        endfunction

        function void restart();
            state     = ST_KEY;
            match_pos = '0;
            hi_nib    = '0;
            written   = '0;
        endfunction

        function void set_register(logic [1:0] idx, logic [63:0] data);
            case (idx)
                ffd_pkg::CFG_FIELD_KEY:      field_key = data;
                ffd_pkg::CFG_KEY_LENGTH:     key_len   = data[3:0];
                ffd_pkg::CFG_VALUE_CAPACITY: capacity  = data[7:0];
                default: ;
            endcase
        endfunction

        function bit hex_digit_val(input logic [7:0] c, output logic [3:0] v);
            v = '0;
            if (c >= ffd_pkg::CH_DIGIT_0 && c <= ffd_pkg::CH_DIGIT_9) begin
                v = 4'(c - ffd_pkg::CH_DIGIT_0);
                return 1'b1;
            end
            if (c >= ffd_pkg::CH_LOWER_A && c <= ffd_pkg::CH_LOWER_F) begin
                v = 4'(c - ffd_pkg::CH_LOWER_A + 8'd10);
                return 1'b1;
            end
            if (c >= ffd_pkg::CH_UPPER_A && c <= ffd_pkg::CH_UPPER_F) begin
                v = 4'(c - ffd_pkg::CH_UPPER_A + 8'd10);
                return 1'b1;
            end
            return 1'b0;
        endfunction

        // outcome when the text stops in the current state
        function logic [2:0] text_end_code();
            case (state)
                ST_VALUE:             return ffd_pkg::OC_OK;
                ST_ESC_HI, ST_ESC_LO: return ffd_pkg::OC_BAD_ESCAPE;
                default:              return ffd_pkg::OC_NOT_FOUND;
            endcase
        endfunction

        // accepted input transfer: work out the result it causes
        function void note_body_byte(logic [7:0] b, logic last);
            t_dec_result r;
            logic        done;
            logic [2:0]  code;
            int unsigned klim;
            logic [3:0]  nib;
            r    = '0;
            done = 1'b0;
            code = ffd_pkg::OC_OK;
            if (state == ST_DRAIN) begin
                if (last) restart();
                pending.push_back(r);
                return;
            end
            klim = (key_len > ffd_pkg::MAX_KEY_BYTES) ? ffd_pkg::MAX_KEY_BYTES : key_len;
            if (b == ffd_pkg::CH_NUL) begin
                code = text_end_code();
                done = 1'b1;
            end else begin
                case (state)
                    ST_KEY: begin
                        if (b == ffd_pkg::CH_AMP) begin
                            match_pos = '0;
                        end else if (match_pos < klim) begin
                            if (b == field_key[8*match_pos[2:0] +: 8]) match_pos++;
                            else state = ST_SKIP;
                        end else if (b == ffd_pkg::CH_EQUAL) begin
                            state   = ST_VALUE;
                            written = '0;
                        end else begin
                            state = ST_SKIP;
                        end
                    end
                    ST_SKIP: begin
                        if (b == ffd_pkg::CH_AMP) begin
                            state     = ST_KEY;
                            match_pos = '0;
                        end
                    end
                    ST_VALUE: begin
                        if (b == ffd_pkg::CH_AMP) begin
                            code = ffd_pkg::OC_OK;
                            done = 1'b1;
                        end else if (int'(written) + 1 >= int'(capacity)) begin
                            code = ffd_pkg::OC_OVERFLOW;
                            done = 1'b1;
                        end else if (b == ffd_pkg::CH_PERCENT) begin
                            state = ST_ESC_HI;
                        end else begin
                            r.value_byte = (b == ffd_pkg::CH_PLUS) ? ffd_pkg::CH_SPACE : b;
                            r.byte_valid = 1'b1;
                        end
                    end
                    ST_ESC_HI: begin
                        if (!hex_digit_val(b, nib)) begin
                            code = ffd_pkg::OC_BAD_ESCAPE;
                            done = 1'b1;
                        end else begin
                            hi_nib = nib;
                            state  = ST_ESC_LO;
                        end
                    end
                    default: begin
                        // low digit of an escape
                        if (!hex_digit_val(b, nib)) begin
                            code = ffd_pkg::OC_BAD_ESCAPE;
                            done = 1'b1;
                        end else if ({hi_nib, nib} == 8'h00) begin
                            code = ffd_pkg::OC_ZERO;
                            done = 1'b1;
                        end else begin
                            r.value_byte = {hi_nib, nib};
                            r.byte_valid = 1'b1;
                            state        = ST_VALUE;
                        end
                    end
                endcase
            end
            if (r.byte_valid) written++;
            if (!done && last) begin
                code = text_end_code();
                done = 1'b1;
            end
            if (done) begin
                r.finished = 1'b1;
                r.outcome  = code;
                if (last) restart();
                else state = ST_DRAIN;
            end
            pending.push_back(r);
        endfunction

        function void report(string what, t_dec_result exp, t_dec_result act);
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
                $display("[%0t] %s: expected byte=%02h bv=%0b fin=%0b oc=%0d",
                         $time, what, exp.value_byte, exp.byte_valid, exp.finished,
                         exp.outcome);
                $display("    got byte=%02h bv=%0b fin=%0b oc=%0d",
                         act.value_byte, act.byte_valid, act.finished, act.outcome);
            end
        endfunction

        // accepted output transfer: compare with the oldest prediction
        function void check_result(t_dec_result act);
            t_dec_result exp;
            string       bad_fields;
            if (pending.size() == 0) begin
                report("result with nothing pending", '0, act);
                return;
            end
            exp        = pending.pop_front();
            bad_fields = "";
            results_checked++;
            if (act.value_byte !== exp.value_byte) bad_fields = {bad_fields, " value_byte"};
            if (act.byte_valid !== exp.byte_valid) bad_fields = {bad_fields, " byte_valid"};
            if (act.finished !== exp.finished)     bad_fields = {bad_fields, " finished"};
            if (act.outcome !== exp.outcome)       bad_fields = {bad_fields, " outcome"};
            if (bad_fields != "") begin
                report({"mismatch on", bad_fields}, exp, act);
            end else begin
                if (exp.byte_valid) bytes_decoded++;
                if (exp.finished && exp.outcome <= ffd_pkg::OC_ZERO)
                    outcome_tally[exp.outcome]++;
            end
        endfunction
    endclass

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [63:0] cfg_data  = '0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    logic [7:0]  body_byte = '0;
    logic        last_byte = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  value_byte;
    logic        byte_valid;
    logic        finished;
    logic [2:0]  outcome;

    form_decode_scoreboard sb = new();

    int unsigned in_idle_pct   = 35;
    int unsigned out_idle_pct  = 35;
    bit          hold_request  = 1'b0;
    int unsigned hold_left     = 0;
    int unsigned quiet_cycles  = 0;
    int unsigned items_sent    = 0;
    int unsigned bodies_sent   = 0;
    int unsigned settings_used = 0;

    // current register values, used to build matching bodies
    logic [63:0] cur_key  = '0;
    logic [3:0]  cur_klen = 4'd1;
    logic [7:0]  cur_cap  = 8'd64;
    logic [7:0]  body_q[$];

    form_field_extract_decode_top DUT (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_body_byte  (body_byte),
        .i_last_byte  (last_byte),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_value_byte (value_byte),
        .o_byte_valid (byte_valid),
        .o_finished   (finished),
        .o_outcome    (outcome)
    );

    always #5 clk = ~clk;

    // Watch both channels; inputs are noted before results are checked
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && in_ready) sb.note_body_byte(body_byte, last_byte);
            if (out_valid && out_ready)
                sb.check_result(t_dec_result'({value_byte, byte_valid, finished, outcome}));
        end
    end

    // Receiver: random stalls, or a long hold-off on request
    always @(posedge clk) begin
        if (hold_left != 0) begin
            out_ready <= 1'b0;
            hold_left--;
        end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
            out_ready   <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(0, 99) >= out_idle_pct);
        end
    end

    // Watchdog: too long without any transfer
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("[%0t] timeout: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
    end

    // Offer one byte, with random idle cycles first
    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(0, 99) < in_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        body_byte <= b;
        last_byte <= last;
        do @(posedge clk); while (!in_ready);
        items_sent++;
    endtask

    task automatic send_body();
        foreach (body_q[i]) send_byte(body_q[i], i == body_q.size() - 1);
        body_q.delete();
        bodies_sent++;
    endtask

    task automatic stop_sending();
        in_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        do @(posedge clk); while (sb.pending.size() != 0);
    endtask

    // Leaves the write enable high; the caller lowers it
    task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.set_register(idx, data);
    endtask

    // Quiesce the block, then load a new key, key length and capacity
    task automatic next_setting(input logic [63:0] key, input logic [3:0] klen,
                                input logic [7:0] cap);
        stop_sending();
        wait_idle();
        write_reg(ffd_pkg::CFG_FIELD_KEY, key);
        write_reg(ffd_pkg::CFG_KEY_LENGTH, 64'(klen));
        write_reg(ffd_pkg::CFG_VALUE_CAPACITY, 64'(cap));
        cfg_we   <= 1'b0;
        cur_key  = key;
        cur_klen = klen;
        cur_cap  = cap;
        settings_used++;
    endtask

    function automatic logic [7:0] name_char();
        int unsigned k = $urandom_range(0, 61);
        if (k < 10) return ffd_pkg::CH_DIGIT_0 + 8'(k);
        if (k < 36) return ffd_pkg::CH_LOWER_A + 8'(k - 10);
        return ffd_pkg::CH_UPPER_A + 8'(k - 36);
    endfunction

    function automatic logic [7:0] hex_char(logic [3:0] n);
        if (n < 10) return ffd_pkg::CH_DIGIT_0 + 8'(n);
        return ($urandom_range(0, 1) ? ffd_pkg::CH_UPPER_A : ffd_pkg::CH_LOWER_A)
               + 8'(n) - 8'd10;
    endfunction

    // Characters next to the hex ranges, plus form syntax
    function automatic logic [7:0] non_hex_char();
        string s = "/:@G`gzZ&%+= ";
        if ($urandom_range(0, 9) == 0) return 8'hFF;
        return s[$urandom_range(0, s.len() - 1)];
    endfunction

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(1, 255));
        while (b == ffd_pkg::CH_AMP || b == ffd_pkg::CH_PERCENT);
        return b;
    endfunction

    function automatic void put_escape();
        int unsigned pick = $urandom_range(0, 99);
        logic [7:0]  v    = 8'($urandom_range(1, 255));
        body_q.push_back(ffd_pkg::CH_PERCENT);
        if (pick < 4) begin
            // decodes to a zero byte
            body_q.push_back(hex_char(4'h0));
            body_q.push_back(hex_char(4'h0));
        end else if (pick < 10) begin
            body_q.push_back(non_hex_char());
        end else if (pick < 16) begin
            body_q.push_back(hex_char(v[7:4]));
            body_q.push_back(non_hex_char());
        end else begin
            body_q.push_back(hex_char(v[7:4]));
            body_q.push_back(hex_char(v[3:0]));
        end
    endfunction

    function automatic void put_value(int unsigned n_elems);
        int unsigned pick;
        repeat (n_elems) begin
            pick = $urandom_range(0, 99);
            if (pick < 15)      body_q.push_back(ffd_pkg::CH_PLUS);
            else if (pick < 32) put_escape();
            else if (pick < 60) body_q.push_back(name_char());
            else                body_q.push_back(plain_byte());
        end
    endfunction

    function automatic void put_key(int unsigned n);
        for (int unsigned i = 0; i < n; i++) body_q.push_back(cur_key[8*i +: 8]);
    endfunction

    // One name=value segment: the key, near misses, or some other name
    function automatic void put_segment();
        int unsigned pick = $urandom_range(0, 99);
        int unsigned klim = (cur_klen > ffd_pkg::MAX_KEY_BYTES) ?
                            ffd_pkg::MAX_KEY_BYTES : cur_klen;
        if (pick < 45) begin
            put_key(klim);
        end else if (pick < 60 && klim > 0) begin
            put_key($urandom_range(0, klim - 1));
            body_q.push_back(name_char());
        end else if (pick < 70) begin
            put_key(klim);
            body_q.push_back(name_char());
        end else if (pick < 75) begin
            return;
        end else begin
            repeat ($urandom_range(1, 5)) body_q.push_back(name_char());
        end
        body_q.push_back(ffd_pkg::CH_EQUAL);
        put_value($urandom_range(0, 8));
    endfunction

    // Mostly well-formed bodies, some cut short or ended early, some noise
    function automatic void build_body();
        int unsigned pick = $urandom_range(0, 99);
        int unsigned segs = $urandom_range(1, 4);
        if (pick < 8) begin
            repeat ($urandom_range(1, 12)) body_q.push_back(8'($urandom_range(0, 255)));
            return;
        end
        for (int unsigned s = 0; s < segs; s++) begin
            if (s != 0) body_q.push_back(ffd_pkg::CH_AMP);
            put_segment();
        end
        if (pick < 15) begin
            // text stops inside an escape
            body_q.push_back(ffd_pkg::CH_PERCENT);
            if ($urandom_range(0, 1)) body_q.push_back(hex_char(4'($urandom_range(0, 15))));
        end else if (pick < 22) begin
            // zero byte ends the text, trailing bytes are dropped
            body_q.push_back(ffd_pkg::CH_NUL);
            repeat ($urandom_range(0, 3)) body_q.push_back(8'($urandom_range(0, 255)));
        end else if (pick < 26) begin
            body_q.push_back(ffd_pkg::CH_AMP);
        end
        if (body_q.size() == 0) body_q.push_back(name_char());
    endfunction

    task automatic run_bodies(input int unsigned n_items);
        int unsigned goal;
        goal = items_sent + n_items;
        while (items_sent < goal) begin
            build_body();
            send_body();
        end
    endtask

    function automatic logic [63:0] random_key();
        logic [63:0] k;
        for (int i = 0; i < 8; i++) k[8*i +: 8] = name_char();
        return k;
    endfunction

    initial begin
        logic [63:0] amp_key;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: key byte is zero so nothing matches; zero ends the text
        body_q = '{"x", ffd_pkg::CH_NUL, "y"};
        send_body();

        // single-char key, capacity 4
        next_setting(64'h6B, 4'd1, 8'd4);
        // escape, plus, value ended by '&', then a dropped byte
        body_q = '{"k", ffd_pkg::CH_EQUAL, ffd_pkg::CH_PERCENT, "4", "A",
                   ffd_pkg::CH_PLUS, ffd_pkg::CH_AMP, 8'hFF};
        send_body();
        // fourth value byte runs over capacity
        body_q = '{"k", ffd_pkg::CH_EQUAL, "a", "b", "c", "d"};
        send_body();
        // escape decoding to zero
        body_q = '{"k", ffd_pkg::CH_EQUAL, ffd_pkg::CH_PERCENT, "0", "0"};
        send_body();
        // zero byte inside an escape
        body_q = '{"k", ffd_pkg::CH_EQUAL, ffd_pkg::CH_PERCENT, ffd_pkg::CH_NUL};
        send_body();

        // longest key, largest capacity, and one value that overruns it
        next_setting(random_key(), 4'd8, 8'd255);
        put_key(8);
        body_q.push_back(ffd_pkg::CH_EQUAL);
        repeat (260) body_q.push_back(name_char());
        send_body();
        run_bodies(60);

        // a stretch of back-to-back transfers, capacity 1
        in_idle_pct  = 0;
        out_idle_pct = 0;
        next_setting(random_key(), 4'd1, 8'd1);
        run_bodies(80);
        in_idle_pct  = 35;
        out_idle_pct = 35;

        // empty key, capacity zero
        next_setting(random_key(), 4'd0, 8'd0);
        run_bodies(60);

        // key length past the maximum; receiver stalls for a long time
        next_setting(random_key(), 4'd15, 8'd2);
        hold_request = 1'b1;
        run_bodies(60);

        // '&' inside the key never matches
        amp_key        = random_key();
        amp_key[15:8]  = ffd_pkg::CH_AMP;
        next_setting(amp_key, 4'd3, 8'd16);
        run_bodies(40);

        // all-ones key
        next_setting('1, 4'd9, 8'd200);
        run_bodies(60);

        // random settings for the rest
        while (items_sent < ITEMS_TARGET) begin
            next_setting(random_key(), 4'($urandom_range(1, 8)), 8'($urandom_range(3, 24)));
            run_bodies(80);
        end

        stop_sending();
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d bytes, %0d bodies, %0d settings; %0d results, %0d value bytes.",
                 items_sent, bodies_sent, settings_used, sb.results_checked, sb.bytes_decoded);
        $display("Outcomes ok %0d, not found %0d, bad escape %0d, overflow %0d, zero %0d.",
                 sb.outcome_tally[ffd_pkg::OC_OK], sb.outcome_tally[ffd_pkg::OC_NOT_FOUND],
                 sb.outcome_tally[ffd_pkg::OC_BAD_ESCAPE],
                 sb.outcome_tally[ffd_pkg::OC_OVERFLOW], sb.outcome_tally[ffd_pkg::OC_ZERO]);
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("%0d mismatches, %0d results outstanding", sb.mismatches,
                     sb.pending.size());
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
